// ----- rtl/cwtc_pkg.sv -----
// shared types, constants and register codes for the conductivity block
package cwtc_pkg;

  // field widths
  localparam int ADC_W      = 10;
  localparam int TEMP_W     = 12;
  localparam int RES_W      = 28;
  localparam int COND_W     = 32;
  localparam int CFG_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int ADC_BITS_DEF = 10;

  // internal arithmetic widths
  localparam int R8_W    = 34;  // unscaled resistance, q8 ohms
  localparam int PROD_W  = 50;  // r8 times scale
  localparam int RAW_W   = 37;  // full width raw conductivity
  localparam int DENOM_W = 30;  // signed q20 compensation denominator
  localparam int DPOS_W  = 29;  // positive denominator
  localparam int COMP_W  = 32;  // compensated quotient bits

  localparam logic [18:0] COND_SCALE = 19'd390625;
  localparam logic signed [DENOM_W-1:0] Q20_ONE = 30'sd1048576;
  localparam logic [RES_W-1:0]  RES_MAX  = '1;
  localparam logic [COND_W-1:0] COND_MAX = '1;

  // register reset values
  localparam logic [15:0] RST_REF_RES     = 16'd1000;
  localparam logic [15:0] RST_RANGE_LIMIT = 16'd300;
  localparam logic [15:0] RST_LOW_SCALE   = 16'd32768;
  localparam logic [15:0] RST_HIGH_SCALE  = 16'd56361;
  localparam logic [17:0] RST_CELL_CONST  = 18'd22216;
  localparam logic [15:0] RST_TEMP_COEFF  = 16'd1245;
  localparam logic signed [11:0] RST_REF_TEMP = 12'sd400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_RES     = 3'd0,
    REG_RANGE_LIMIT = 3'd1,
    REG_LOW_SCALE   = 3'd2,
    REG_HIGH_SCALE  = 3'd3,
    REG_CELL_CONST  = 3'd4,
    REG_TEMP_COEFF  = 3'd5,
    REG_REF_TEMP    = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DROP   = 2'd1,
    ST_BAD_COMP  = 2'd2,
    ST_SAT       = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADC_W-1:0]         adc_high;
    logic [ADC_W-1:0]         adc_low;
    logic signed [TEMP_W-1:0] water_temp;
  } sample_t;

  typedef struct packed {
    logic [RES_W-1:0]  resistance;
    logic [COND_W-1:0] raw_conductivity;
    logic [COND_W-1:0] comp_conductivity;
    status_t           status;
  } result_t;

  // flags that ride along the first divider
  typedef struct packed {
    logic              nodrop;
    logic              bigd;
    logic              badcomp;
    logic [DPOS_W-1:0] denom;
  } side1_t;

  // flags that ride along the second divider
  typedef struct packed {
    side1_t           s;
    logic             res_sat;
    logic             rs_zero;
    logic [RES_W-1:0] res;
  } side2_t;

  // flags that ride along the third divider
  typedef struct packed {
    side2_t            s;
    logic              raw_sat;
    logic              comp_sat;
    logic [COND_W-1:0] raw;
  } side3_t;

endpackage

// ----- rtl/cwtc_stream_if.sv -----
// valid/ready stream channel carrying one request payload
interface cwtc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/cwtc_div.sv -----
// pipelined restoring divider, one quotient bit per stage, sideband carried along
module cwtc_div #(
  parameter int DEN_W  = 17,
  parameter int QUO_W  = 34,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  rem_in,   // must be below den_in
  input  logic [QUO_W-1:0]  low_in,
  input  logic [DEN_W-1:0]  den_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo_out,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld  [QUO_W];
  logic [DEN_W-1:0]  rem  [QUO_W];
  logic [QUO_W-1:0]  low  [QUO_W];
  logic [DEN_W-1:0]  den  [QUO_W];
  logic [SIDE_W-1:0] side [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic              src_vld;
    logic [DEN_W-1:0]  src_rem;
    logic [QUO_W-1:0]  src_low;
    logic [DEN_W-1:0]  src_den;
    logic [SIDE_W-1:0] src_side;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = rem_in;
      assign src_low  = low_in;
      assign src_den  = den_in;
      assign src_side = side_in;
    end else begin : g_next
      assign src_vld  = vld[i-1];
      assign src_rem  = rem[i-1];
      assign src_low  = low[i-1];
      assign src_den  = den[i-1];
      assign src_side = side[i-1];
    end

    // shift in the next numerator bit and try the subtract
    assign trial = {src_rem, src_low[QUO_W-1]};
    assign ge    = trial >= {1'b0, src_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? DEN_W'(trial - {1'b0, src_den}) : DEN_W'(trial);
        low[i]  <= {src_low[QUO_W-2:0], ge};
        den[i]  <= src_den;
        side[i] <= src_side;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quo_out   = low[QUO_W-1];
  assign side_out  = side[QUO_W-1];

endmodule

// ----- rtl/conductivity_with_temp_compensation.sv -----
// conductivity meter with linear temperature compensation, top level
//
// sample channel: two adc counts across the electrode divider and the water
// temperature. result channel: scaled resistance (q8 ohms), raw and
// compensated conductivity (0.01 uS/cm) and a status code.
// configuration: cfg_we / cfg_index / cfg_data write one register per cycle;
// write only while no request is in flight.
// throughput: one request per cycle while the output queue is not full. stages in
// order: two setup stages, a 34 stage resistance divider, scale multiply,
// resistance check stage, 37 stage conductivity divider, compare stage,
// 32 stage compensation divider, output queue.
// the pipeline moves as one; a two entry output queue takes results while the
// receiver stalls and the pipeline (and sample.ready) halts only when it is full.
// reset clears all valid bits and the queue and loads the register defaults.
module conductivity_with_temp_compensation #(
  parameter int ADC_BITS = cwtc_pkg::ADC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  cwtc_stream_if.sink                    sample,
  cwtc_stream_if.source                  result,
  input  logic                           cfg_we,
  input  logic [cwtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwtc_pkg::CFG_W-1:0]     cfg_data
);
  import cwtc_pkg::*;

  localparam int DEN1_W = ADC_BITS + 1;
  localparam logic [16:0] FULL = 17'(1 << ADC_BITS);

  // configuration registers
  logic [15:0]        ref_resistance;
  logic [15:0]        range_limit;
  logic [15:0]        low_scale;
  logic [15:0]        high_scale;
  logic [17:0]        cell_constant;
  logic [15:0]        temp_coeff;
  logic signed [11:0] ref_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_resistance <= RST_REF_RES;
      range_limit    <= RST_RANGE_LIMIT;
      low_scale      <= RST_LOW_SCALE;
      high_scale     <= RST_HIGH_SCALE;
      cell_constant  <= RST_CELL_CONST;
      temp_coeff     <= RST_TEMP_COEFF;
      ref_temp       <= RST_REF_TEMP;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REF_RES:     ref_resistance <= cfg_data[15:0];
        REG_RANGE_LIMIT: range_limit    <= cfg_data[15:0];
        REG_LOW_SCALE:   low_scale      <= cfg_data[15:0];
        REG_HIGH_SCALE:  high_scale     <= cfg_data[15:0];
        REG_CELL_CONST:  cell_constant  <= cfg_data;
        REG_TEMP_COEFF:  temp_coeff     <= cfg_data[15:0];
        REG_REF_TEMP:    ref_temp       <= $signed(cfg_data[11:0]);
        default: ;
      endcase
    end
  end

  // pipeline advance, held only by a full output queue
  logic [1:0] fill;
  logic       en;
  assign en = fill != 2'd2;
  assign sample.ready = en;

  // stage a: drop, divider product, temperature difference
  logic               a_valid;
  logic               a_nodrop;
  logic [ADC_W-1:0]   a_d;
  logic [25:0]        a_num;
  logic signed [12:0] a_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_nodrop <= sample.data.adc_high <= sample.data.adc_low;
      a_d      <= sample.data.adc_high - sample.data.adc_low;
      a_num    <= 26'(ref_resistance) * 26'(sample.data.adc_high - sample.data.adc_low);
      a_diff   <= $signed({sample.data.water_temp[TEMP_W-1], sample.data.water_temp})
                - $signed({ref_temp[11], ref_temp});
    end
  end

  // stage b: full scale check, divisor, compensation denominator
  logic                      b_valid;
  side1_t                    b_side;
  logic [R8_W-1:0]           b_num;
  logic [DEN1_W-1:0]         b_den;
  logic                      b_bigd;
  logic signed [DENOM_W-1:0] b_denom;

  assign b_bigd  = {7'd0, a_d} >= FULL;
  assign b_denom = Q20_ONE + $signed({1'b0, temp_coeff}) * a_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side.nodrop  <= a_nodrop;
      b_side.bigd    <= b_bigd;
      b_side.badcomp <= b_denom <= 0;
      b_side.denom   <= b_denom[DPOS_W-1:0];
      b_num          <= {a_num, 8'd0};
      b_den          <= b_bigd ? DEN1_W'(1) : DEN1_W'(FULL - {7'd0, a_d});
    end
  end

  // unscaled resistance in q8 ohms
  logic            d1_valid;
  logic [R8_W-1:0] d1_quo;
  side1_t          d1_side;

  cwtc_div #(
    .DEN_W  (DEN1_W),
    .QUO_W  (R8_W),
    .SIDE_W ($bits(side1_t))
  ) u_div_res (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .rem_in    ('0),
    .low_in    (b_num),
    .den_in    (b_den),
    .side_in   (b_side),
    .out_valid (d1_valid),
    .quo_out   (d1_quo),
    .side_out  (d1_side)
  );

  // stage c: range select and scale multiply
  logic              c_valid;
  side1_t            c_side;
  logic [PROD_W-1:0] c_prod;
  logic [15:0]       c_scale;

  assign c_scale = (d1_quo < R8_W'({range_limit, 8'd0})) ? low_scale : high_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= d1_side;
      c_prod <= PROD_W'(d1_quo) * PROD_W'(c_scale);
    end
  end

  // stage d: scaled resistance checks, conductivity numerator
  logic            d_valid;
  side2_t          d_side;
  logic [R8_W-1:0] d_den;
  logic [RAW_W-1:0] d_num;
  logic [R8_W-1:0] d_rs;
  logic            d_rs_sat;

  assign d_rs     = c_prod[PROD_W-1:16];
  assign d_rs_sat = |d_rs[R8_W-1:RES_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side.s       <= c_side;
      d_side.res_sat <= d_rs_sat;
      d_side.rs_zero <= d_rs == '0;
      d_side.res     <= d_rs_sat ? RES_MAX : d_rs[RES_W-1:0];
      d_den          <= (d_rs == '0) ? R8_W'(1) : d_rs;
      d_num          <= RAW_W'(cell_constant) * RAW_W'(COND_SCALE);
    end
  end

  // raw conductivity at full width
  logic             d2_valid;
  logic [RAW_W-1:0] d2_quo;
  side2_t           d2_side;

  cwtc_div #(
    .DEN_W  (R8_W),
    .QUO_W  (RAW_W),
    .SIDE_W ($bits(side2_t))
  ) u_div_raw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .rem_in    ('0),
    .low_in    (d_num),
    .den_in    (d_den),
    .side_in   (d_side),
    .out_valid (d2_valid),
    .quo_out   (d2_quo),
    .side_out  (d2_side)
  );

  // stage e: raw saturation, compensation overflow check
  logic              e_valid;
  side3_t            e_side;
  logic [DPOS_W-1:0] e_rem;
  logic [DPOS_W-1:0] e_den;
  logic [COMP_W-1:0] e_low;
  logic              e_raw_sat;
  logic              e_comp_sat;
  logic              e_skip;

  assign e_raw_sat  = |d2_quo[RAW_W-1:COND_W];
  // the quotient of raw << 20 by the divisor overflows 32 bits exactly when the top part of raw reaches the divisor
  assign e_comp_sat = DPOS_W'(d2_quo[RAW_W-1:12]) >= d2_side.s.denom;
  assign e_skip     = e_comp_sat | d2_side.s.badcomp;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side.s        <= d2_side;
      e_side.raw_sat  <= e_raw_sat;
      e_side.comp_sat <= e_comp_sat;
      e_side.raw      <= e_raw_sat ? COND_MAX : d2_quo[COND_W-1:0];
      e_rem           <= e_skip ? '0 : DPOS_W'(d2_quo[RAW_W-1:12]);
      e_den           <= e_skip ? DPOS_W'(1) : d2_side.s.denom;
      e_low           <= e_skip ? '0 : {d2_quo[11:0], 20'd0};
    end
  end

  // compensated conductivity
  logic              d3_valid;
  logic [COMP_W-1:0] d3_quo;
  side3_t            d3_side;

  cwtc_div #(
    .DEN_W  (DPOS_W),
    .QUO_W  (COMP_W),
    .SIDE_W ($bits(side3_t))
  ) u_div_comp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .rem_in    (e_rem),
    .low_in    (e_low),
    .den_in    (e_den),
    .side_in   (e_side),
    .out_valid (d3_valid),
    .quo_out   (d3_quo),
    .side_out  (d3_side)
  );

  // result assembly and status priority
  result_t f_res;
  logic    f_sat;

  always_comb begin
    f_res = '0;
    f_sat = d3_side.s.s.bigd | d3_side.s.res_sat | d3_side.s.rs_zero
          | d3_side.raw_sat | d3_side.comp_sat;
    if (d3_side.s.s.nodrop) begin
      f_res.status = ST_NO_DROP;
    end else begin
      f_res.resistance = d3_side.s.s.bigd ? RES_MAX : d3_side.s.res;
      priority if (d3_side.s.s.bigd) begin
        f_res.raw_conductivity = '0;
      end else if (d3_side.s.rs_zero) begin
        f_res.raw_conductivity = COND_MAX;
      end else begin
        f_res.raw_conductivity = d3_side.raw;
      end
      priority if (d3_side.s.s.badcomp || d3_side.s.s.bigd) begin
        f_res.comp_conductivity = '0;
      end else if (d3_side.s.rs_zero || d3_side.comp_sat) begin
        f_res.comp_conductivity = COND_MAX;
      end else begin
        f_res.comp_conductivity = d3_quo;
      end
      priority if (d3_side.s.s.badcomp) begin
        f_res.status = ST_BAD_COMP;
      end else if (f_sat) begin
        f_res.status = ST_SAT;
      end else begin
        f_res.status = ST_OK;
      end
    end
  end

  // two entry output queue
  result_t q_data [2];
  logic    wr_ptr;
  logic    rd_ptr;
  logic    push;
  logic    pop;

  assign push = en & d3_valid;
  assign pop  = result.valid & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      fill   <= fill + 2'(push) - 2'(pop);
      wr_ptr <= wr_ptr ^ push;
      rd_ptr <= rd_ptr ^ pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[wr_ptr] <= f_res;
    end
  end

  assign result.valid = fill != 2'd0;
  assign result.data  = q_data[rd_ptr];

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("output queue overfilled");

  a_nodrop_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.status == ST_NO_DROP |->
      result.data.resistance == '0 && result.data.raw_conductivity == '0 &&
      result.data.comp_conductivity == '0)
    else $error("no-drop result carries nonzero fields");

  a_badcomp_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.status == ST_BAD_COMP |->
      result.data.comp_conductivity == '0)
    else $error("bad compensation result carries nonzero conductivity");

endmodule
